// File: rtl/pcgrr_pkg.sv
// pcgrr_pkg: shared types and constants for the ranged pcg-hash generator
// payload structs, mode codes, hash constants, controller states and
// the command/status structs between controller and datapath
package pcgrr_pkg;

  // hash constants
  localparam logic [31:0] MUL_A = 32'd747796405;
  localparam logic [31:0] ADD_A = 32'd2891336453;
  localparam logic [31:0] MUL_B = 32'd277803737;
  localparam logic [3:0]  XSH_BIAS = 4'd4;
  localparam int unsigned FOLD_SHIFT = 22;

  // remainder unit: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // request modes
  localparam logic [1:0] MODE_BOOL   = 2'd0;
  localparam logic [1:0] MODE_RAW    = 2'd1;
  localparam logic [1:0] MODE_SRANGE = 2'd2;
  localparam logic [1:0] MODE_URANGE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] range_min;
    logic [31:0] range_max;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_XSH,
    ST_MUL_B,
    ST_FOLD,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_a;
    logic xsh;
    logic mul_b;
    logic fold;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic range_mode;
    logic reversed;
    logic span_zero;
    logic div_last;
  } status_t;

endpackage

// File: rtl/pcgrr_ctrl.sv
// pcgrr_ctrl: sequencer for one request at a time
// depends on pcgrr_pkg for the state enum and the command/status structs
module pcgrr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcgrr_pkg::status_t status,
  output pcgrr_pkg::cmd_t   cmd
);

  pcgrr_pkg::state_t state, state_next;
  logic out_full;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcgrr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  assign out_valid = out_full;
  assign in_ready  = (state == pcgrr_pkg::ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      pcgrr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = pcgrr_pkg::ST_MUL_A;
        end
      end
      pcgrr_pkg::ST_MUL_A: begin
        // rejected bounds skip the hash, state untouched
        if (status.range_mode && status.reversed) begin
          state_next = pcgrr_pkg::ST_FINISH;
        end else begin
          cmd.mul_a  = 1'b1;
          state_next = pcgrr_pkg::ST_XSH;
        end
      end
      pcgrr_pkg::ST_XSH: begin
        cmd.xsh    = 1'b1;
        state_next = pcgrr_pkg::ST_MUL_B;
      end
      pcgrr_pkg::ST_MUL_B: begin
        cmd.mul_b  = 1'b1;
        state_next = pcgrr_pkg::ST_FOLD;
      end
      pcgrr_pkg::ST_FOLD: begin
        cmd.fold = 1'b1;
        if (status.range_mode && !status.span_zero) begin
          state_next = pcgrr_pkg::ST_DIV;
        end else begin
          state_next = pcgrr_pkg::ST_FINISH;
        end
      end
      pcgrr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = pcgrr_pkg::ST_FINISH;
        end
      end
      pcgrr_pkg::ST_FINISH: begin
        // wait for the output register to be free
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = pcgrr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pcgrr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pcgrr_dp.sv
// pcgrr_dp: generator state, hash multiplier steps, bit-serial remainder
// unit and output register; depends on pcgrr_pkg
module pcgrr_dp (
  input  logic               clk,
  input  logic               rst,
  input  pcgrr_pkg::in_t     in_data,
  input  logic               cfg_valid,
  input  logic [31:0]        cfg_data,
  input  pcgrr_pkg::cmd_t    cmd,
  output pcgrr_pkg::status_t status,
  output pcgrr_pkg::out_t    out_data
);

  pcgrr_pkg::in_t               req;
  logic [31:0]                  gen_state;
  logic [31:0]                  hash_tmp;
  logic [31:0]                  dvd;
  logic [31:0]                  rem;
  logic [pcgrr_pkg::DIV_CNT_W-1:0] div_cnt;
  pcgrr_pkg::out_t              out_reg;

  logic [31:0] span;
  logic        reversed;
  logic        range_mode;
  logic [4:0]  xsh_amt;
  logic [31:0] folded;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  pcgrr_pkg::out_t result;

  // bound check and span on the captured request
  assign range_mode = (req.mode == pcgrr_pkg::MODE_SRANGE) ||
                      (req.mode == pcgrr_pkg::MODE_URANGE);
  assign span       = req.range_max - req.range_min + 32'd1;
  always_comb begin
    if (req.mode == pcgrr_pkg::MODE_SRANGE) begin
      reversed = $signed(req.range_max) < $signed(req.range_min);
    end else begin
      reversed = req.range_max < req.range_min;
    end
  end

  // data-dependent shift amount and final fold
  assign xsh_amt = {1'b0, hash_tmp[31:28]} + {1'b0, pcgrr_pkg::XSH_BIAS};
  assign folded  = (hash_tmp >> pcgrr_pkg::FOLD_SHIFT) ^ hash_tmp;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  // running generator state: seed write or end of hash
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= '0;
    end else if (cfg_valid) begin
      gen_state <= cfg_data;
    end else if (cmd.fold) begin
      gen_state <= folded;
    end
  end

  // hash temporaries, at most one multiply per cycle
  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      hash_tmp <= gen_state * pcgrr_pkg::MUL_A + pcgrr_pkg::ADD_A;
    end else if (cmd.xsh) begin
      hash_tmp <= (hash_tmp >> xsh_amt) ^ hash_tmp;
    end else if (cmd.mul_b) begin
      hash_tmp <= hash_tmp * pcgrr_pkg::MUL_B;
    end
  end

  // restoring remainder step
  assign rem_sh   = {rem, dvd[31]};
  assign rem_diff = rem_sh - {1'b0, span};

  always_ff @(posedge clk) begin
    if (cmd.fold) begin
      dvd     <= folded;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      dvd     <= {dvd[30:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
      if (!rem_diff[32]) begin
        rem <= rem_diff[31:0];
      end else begin
        rem <= rem_sh[31:0];
      end
    end
  end

  // result select
  always_comb begin
    result = '0;
    if (range_mode && reversed) begin
      result.range_error = 1'b1;
    end else begin
      unique case (req.mode)
        pcgrr_pkg::MODE_BOOL:   result.value = {31'd0, ~gen_state[0]};
        pcgrr_pkg::MODE_RAW:    result.value = gen_state;
        pcgrr_pkg::MODE_SRANGE,
        pcgrr_pkg::MODE_URANGE: begin
          if (span == '0) begin
            result.value = req.range_min + gen_state;
          end else begin
            result.value = req.range_min + rem;
          end
        end
        default: result.value = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_reg <= result;
    end
  end

  assign out_data          = out_reg;
  assign status.range_mode = range_mode;
  assign status.reversed   = reversed;
  assign status.span_zero  = (span == '0);
  assign status.div_last   = (div_cnt == pcgrr_pkg::DIV_CNT_W'(pcgrr_pkg::DIV_STEPS - 1));

endmodule

// File: rtl/pcg_hash_random_ranged.sv
// bool, raw and full-span range requests step through ST_MUL_A, ST_XSH, ST_MUL_B, ST_FOLD
// and ST_FINISH; rejected bounds jump from ST_MUL_A to ST_FINISH; other range requests add
// ST_DIV (the remainder unit) after ST_FOLD; one request at a time: the next one is accepted
// in ST_IDLE, entered as the result is registered, while the result may wait in the output register
// reset (rst, synchronous): controller idle, output empty, generator state 0
// seed writes (cfg channel, always ready) reload the generator state
module pcg_hash_random_ranged (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pcgrr_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pcgrr_pkg::out_t out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);

  pcgrr_pkg::cmd_t    cmd;
  pcgrr_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  pcgrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  pcgrr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

  // an accepted transaction makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a transaction is in progress");

  // rejected bounds carry a zero value
  a_error_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_error |-> out_data.value == '0)
    else $error("range error with non-zero value");

  // a result is never taken out of the output register before its transaction
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending output dropped");

endmodule

// File: verif/testbench.sv
// testbench for pcg_hash_random_ranged: directed table, then seeded random phases
// holds its own model of the hash and the ranged draw, checks every result in order
// depends on rtl/pcgrr_pkg.sv and rtl/pcg_hash_random_ranged.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // hash constants of the generator
  localparam logic [31:0] HASH_MUL_FIRST  = 32'd747796405;
  localparam logic [31:0] HASH_INCREMENT  = 32'd2891336453;
  localparam logic [31:0] HASH_MUL_SECOND = 32'd277803737;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned PHASE_ITEMS     = 200;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 50;

  typedef struct packed {
    pcgrr_pkg::in_t  req;
    logic            fixed;
    pcgrr_pkg::out_t result;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pcgrr_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pcgrr_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // model state and expected results
  logic [31:0] gen_state = '0;
  pcgrr_pkg::out_t pending_draws[$];
  table_row_t directed_rows[$];

  // idling control and counters
  bit gaps_on = 1'b1;
  bit hold_off_go = 1'b0;
  bit hold_off_taken = 1'b0;
  int unsigned hold_left = 0;
  int unsigned fail_count = 0;
  int unsigned draws_checked = 0;
  int unsigned rejects_seen = 0;
  int unsigned seeds_written = 0;

  pcg_hash_random_ranged dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // one step of the pcg hash, all arithmetic mod 2^32
  function automatic logic [31:0] pcg_hash(input logic [31:0] s);
    logic [31:0] t;
    int unsigned sh;
    t = s * HASH_MUL_FIRST + HASH_INCREMENT;
    sh = int'(t[31:28]) + 4;
    t = ((t >> sh) ^ t) * HASH_MUL_SECOND;
    return (t >> 22) ^ t;
  endfunction

  function automatic bit bounds_reversed(input logic [1:0] mode, input logic [31:0] lo,
                                         input logic [31:0] hi);
    if (mode == pcgrr_pkg::MODE_SRANGE)
      return $signed(hi) < $signed(lo);
    return hi < lo;
  endfunction

  // expected result of one request; advances the model state unless the bounds are rejected
  function automatic pcgrr_pkg::out_t predict_draw(input pcgrr_pkg::in_t req);
    pcgrr_pkg::out_t r;
    logic [31:0] span;
    r = '0;
    case (req.mode)
      pcgrr_pkg::MODE_BOOL: begin
        gen_state = pcg_hash(gen_state);
        r.value = {31'b0, ~gen_state[0]};
      end
      pcgrr_pkg::MODE_RAW: begin
        gen_state = pcg_hash(gen_state);
        r.value = gen_state;
      end
      default: begin
        if (bounds_reversed(req.mode, req.range_min, req.range_max)) begin
          r.range_error = 1'b1;
        end else begin
          span = req.range_max - req.range_min + 32'd1;
          gen_state = pcg_hash(gen_state);
          // full 32-bit span wraps to zero: no reduction
          if (span == 32'd0)
            r.value = req.range_min + gen_state;
          else
            r.value = req.range_min + gen_state % span;
        end
      end
    endcase
    return r;
  endfunction

  function automatic pcgrr_pkg::in_t random_request();
    pcgrr_pkg::in_t r;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] tmp;
    int unsigned pick;
    r.mode = 2'($urandom_range(3));
    lo = $urandom;
    hi = $urandom;
    pick = $urandom_range(99);
    // picks below 15 leave the random pair untouched, so its bounds may be reversed; the rest are made well formed
    if (pick >= 15) begin
      if (pick < 45) begin
        hi = lo + $urandom_range(64);
      end else if (pick < 60) begin
        hi = lo + ((32'd1 << $urandom_range(31)) - 32'd1);
      end else if (pick < 70) begin
        lo = (r.mode == pcgrr_pkg::MODE_SRANGE) ? 32'h8000_0000 : 32'h0;
        hi = lo - 32'd1;
      end
      if (bounds_reversed(r.mode, lo, hi)) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end
    r.range_min = lo;
    r.range_max = hi;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [31:0] lo,
                                  input logic [31:0] hi, input logic fixed,
                                  input logic [31:0] value, input logic err);
    table_row_t row;
    row.req = '{mode: mode, range_min: lo, range_max: hi};
    row.fixed = fixed;
    row.result = '{value: value, range_error: err};
    directed_rows.push_back(row);
  endfunction

  // offer one request, hold it until accepted, then record its expectation
  task automatic send_request(input pcgrr_pkg::in_t req, input logic fixed,
                              input pcgrr_pkg::out_t fixed_result);
    pcgrr_pkg::out_t want;
    if (gaps_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = predict_draw(req);
    if (fixed) want = fixed_result;
    pending_draws.push_back(want);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  // seed write, only issued with the block idle
  task automatic write_seed(input logic [31:0] seed);
    cfg_data <= seed;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gen_state = seed;
    seeds_written++;
  endtask

  // result receiver: random idling plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off_go && !hold_off_taken) begin
      hold_off_taken <= 1'b1;
      hold_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(gaps_on && $urandom_range(99) < 20);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    pcgrr_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_draws.size() == 0) begin
        $display("%0t: result with none expected: value=%h range_error=%b", $time,
                 out_data.value, out_data.range_error);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        draws_checked++;
        if (out_data.range_error) rejects_seen++;
        if (out_data.value !== want.value) begin
          $display("%0t: value mismatch: expected %h, got %h", $time, want.value,
                   out_data.value);
          fail_count++;
        end
        if (out_data.range_error !== want.range_error) begin
          $display("%0t: range_error mismatch: expected %b, got %b", $time,
                   want.range_error, out_data.range_error);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] phase_seeds [PHASES];
    table_row_t row;
    pcgrr_pkg::in_t req;

    // bounds ignored outside range modes, extremes, reversed bounds, single-value ranges and full spans
    add_row(pcgrr_pkg::MODE_BOOL,   32'h0000_0000, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_RAW,    32'h0000_0000, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_BOOL,   32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_RAW,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0000, 32'h0000_0009, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'hFFFF_FFF6, 32'h0000_000A, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'hFFFF_FFF6, 32'h0000_000A, 1'b1, '0, 1'b1);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '0, 1'b1);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0005, 32'h0000_0004, 1'b1, '0, 1'b1);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0, 1'b1);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_04D2, 32'h0000_04D2, 1'b1, 32'h0000_04D2, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_URANGE, 32'h0000_0000, 32'h0000_0001, 1'b0, '0, 1'b0);
    add_row(pcgrr_pkg::MODE_SRANGE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0, 1'b0);

    phase_seeds[0] = 32'hFFFF_FFFF;
    phase_seeds[1] = 32'h0000_0000;
    phase_seeds[2] = 32'h8000_0000;
    phase_seeds[3] = 32'h7FFF_FFFF;
    phase_seeds[4] = $urandom;
    phase_seeds[5] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table from the reset state
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.req, row.fixed, row.result);
    end

    // random phases, each from a fresh seed
    for (int unsigned p = 0; p < PHASES; p++) begin
      drain_results();
      write_seed(phase_seeds[p]);
      gaps_on = (p != 3);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 50) hold_off_go <= 1'b1;
        if (p == 2 && n == 100) drain_results();
        req = random_request();
        send_request(req, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("checked %0d results over %0d seed settings, %0d of them rejected bounds",
             draws_checked, seeds_written + 1, rejects_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_draws.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
